// ===== src/rv32e_pkg.sv =====
// Package for the partial RV32I execute unit.
// Opcodes, funct codes, status codes and payload types. No dependencies.
package rv32e_pkg;

  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] F7_ALT     = 7'b0100000;
  localparam logic [2:0] LEN_LONG   = 3'b111;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ILLEGAL  = 3'd1,
    ST_MISALIGN = 3'd2,
    ST_LFAULT   = 3'd3,
    ST_PENDING  = 3'd4,
    ST_BUSY     = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    F3_BEQ  = 3'd0,
    F3_BNE  = 3'd1,
    F3_BLT  = 3'd4,
    F3_BGE  = 3'd5,
    F3_BLTU = 3'd6,
    F3_BGEU = 3'd7
  } br_f3_e;

  typedef enum logic [2:0] {
    F3_ADDI  = 3'd0,
    F3_SLLI  = 3'd1,
    F3_SLTI  = 3'd2,
    F3_SLTIU = 3'd3,
    F3_XORI  = 3'd4,
    F3_SRI   = 3'd5,
    F3_ORI   = 3'd6,
    F3_ANDI  = 3'd7
  } alu_f3_e;

  typedef enum logic [2:0] {
    F3_LB  = 3'd0,
    F3_LH  = 3'd1,
    F3_LW  = 3'd2,
    F3_LBU = 3'd4,
    F3_LHU = 3'd5
  } ld_f3_e;

  typedef struct packed {
    logic [31:0] rd_value;
    logic [4:0]  rd_index;
    logic        rd_write;
    logic [1:0]  mem_size;
    logic [31:0] mem_addr;
    logic        mem_req;
    logic [31:0] next_pc;
    status_e     status;
  } result_t;

endpackage

// ===== src/rv32i_base_execute_unit.sv =====
// Partial RV32I execute unit: register file, pc, one outstanding load.
// Depends on rv32e_pkg.
//
//  channel | group          | tdata (low bit up)                        | tuser
//  in      | s_axis_*       | instr_word, load_data, load_fault         | mode
//  out     | m_axis_*       | next_pc, mem_req, mem_addr, mem_size,     | status
//          |                | rd_write, rd_index, rd_value              |
//
// One transaction per cycle unless stalled; results are registered.
// Register file and pc update in the accept cycle, so the next transaction
// sees them at once. Output register with skid stage: s_axis_tready only
// drops when both hold results. Reset clears pc, register file and load state.
module rv32i_base_execute_unit
  import rv32e_pkg::*;
#(
  parameter int NUM_REGS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,  // instr_word, load_data, load_fault, pad
  input  logic         s_axis_tuser,  // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,  // next_pc, mem_req, mem_addr, mem_size,
                                      // rd_write, rd_index, rd_value, pad
  output logic [2:0]   m_axis_tuser   // status
);

  logic [31:0] rf_q [1:31];
  logic [31:0] pc_q, pc_d;
  logic        lp_q, lp_d;
  logic [4:0]  pdst_q, pdst_d;
  logic [2:0]  pkind_q, pkind_d;

  result_t res;
  result_t out_q, skid_q;
  logic    out_vld_q, skid_vld_q;
  logic    acc;

  logic [31:0] w, ld, a, b, immi, immu, immb, immj, tgt, wval, sd;
  logic [4:0]  rd, rs1, rs2;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic        wr, cond;

  function automatic logic reg_ok(logic [4:0] idx);
    return {27'd0, idx} < NUM_REGS;
  endfunction

  assign acc = s_axis_tvalid && s_axis_tready;
  assign w   = s_axis_tdata[31:0];
  assign ld  = s_axis_tdata[63:32];
  assign rd  = w[11:7];
  assign rs1 = w[19:15];
  assign rs2 = w[24:20];
  assign f3  = w[14:12];
  assign f7  = w[31:25];
  assign a   = (rs1 == 5'd0) ? 32'd0 : rf_q[rs1];
  assign b   = (rs2 == 5'd0) ? 32'd0 : rf_q[rs2];
  assign immi = {{20{w[31]}}, w[31:20]};
  assign immu = {w[31:12], 12'd0};
  assign immb = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
  assign immj = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
  assign sd   = $signed(a) >>> rs2;

  always_comb begin
    res = '0;
    res.status = ST_OK;
    pc_d = pc_q; lp_d = lp_q; pdst_d = pdst_q; pkind_d = pkind_q;
    wr = 1'b0; wval = '0; cond = 1'b0; tgt = '0;
    if (s_axis_tuser) begin
      if (lp_q) begin
        if (s_axis_tdata[64]) begin
          res.status = ST_LFAULT;
        end else begin
          case (pkind_q)
            F3_LB:   wval = {{24{ld[7]}}, ld[7:0]};
            F3_LH:   wval = {{16{ld[15]}}, ld[15:0]};
            F3_LBU:  wval = {24'd0, ld[7:0]};
            F3_LHU:  wval = {16'd0, ld[15:0]};
            default: wval = ld;
          endcase
          wr = 1'b1;
          pc_d = pc_q + 32'd4;
        end
        lp_d = 1'b0;
      end
    end else if (lp_q) begin
      res.status = ST_BUSY;
    end else if (w[1:0] != 2'b11 || w[4:2] == LEN_LONG) begin
      res.status = ST_ILLEGAL;
    end else begin
      case (w[6:0])
        OPC_LUI, OPC_AUIPC: begin
          if (!reg_ok(rd)) res.status = ST_ILLEGAL;
          else begin
            wr = 1'b1;
            wval = (w[6:0] == OPC_LUI) ? immu : pc_q + immu;
            pc_d = pc_q + 32'd4;
          end
        end
        OPC_JAL: begin
          tgt = pc_q + immj;
          if (!reg_ok(rd)) res.status = ST_ILLEGAL;
          else if (tgt[1]) res.status = ST_MISALIGN;
          else begin
            wr = 1'b1; wval = pc_q + 32'd4; pc_d = tgt;
          end
        end
        OPC_JALR: begin
          tgt = (a + immi) & ~32'd1;
          if (f3 != 3'd0 || !reg_ok(rd) || !reg_ok(rs1)) res.status = ST_ILLEGAL;
          else if (tgt[1]) res.status = ST_MISALIGN;
          else begin
            wr = 1'b1; wval = pc_q + 32'd4; pc_d = tgt;
          end
        end
        OPC_BRANCH: begin
          case (f3)
            F3_BEQ:  cond = (a == b);
            F3_BNE:  cond = (a != b);
            F3_BLT:  cond = ($signed(a) < $signed(b));
            F3_BGE:  cond = ($signed(a) >= $signed(b));
            F3_BLTU: cond = (a < b);
            default: cond = (a >= b);
          endcase
          tgt = pc_q + immb;
          if (f3 == 3'd2 || f3 == 3'd3 || !reg_ok(rs1) || !reg_ok(rs2))
            res.status = ST_ILLEGAL;
          else if (cond && tgt[1]) res.status = ST_MISALIGN;
          else pc_d = cond ? tgt : pc_q + 32'd4;
        end
        OPC_LOAD: begin
          if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7 || !reg_ok(rd) || !reg_ok(rs1))
            res.status = ST_ILLEGAL;
          else begin
            res.mem_req = 1'b1;
            res.mem_addr = a + immi;
            res.mem_size = f3[1:0];
            lp_d = 1'b1; pdst_d = rd; pkind_d = f3;
            res.status = ST_PENDING;
          end
        end
        OPC_OPIMM: begin
          case (f3)
            F3_ADDI:  wval = a + immi;
            F3_SLLI:  wval = a << rs2;
            F3_SLTI:  wval = {31'd0, $signed(a) < $signed(immi)};
            F3_SLTIU: wval = {31'd0, a < immi};
            F3_XORI:  wval = a ^ immi;
            F3_SRI:   wval = (f7 == F7_ALT) ? sd : a >> rs2;
            F3_ORI:   wval = a | immi;
            default:  wval = a & immi;
          endcase
          if (!reg_ok(rd) || !reg_ok(rs1) ||
              (f3 == F3_SLLI && f7 != 7'd0) ||
              (f3 == F3_SRI && f7 != 7'd0 && f7 != F7_ALT))
            res.status = ST_ILLEGAL;
          else begin
            wr = 1'b1; pc_d = pc_q + 32'd4;
          end
        end
        default: res.status = ST_ILLEGAL;
      endcase
    end
    res.next_pc = pc_d;
    if (wr) begin
      res.rd_index = s_axis_tuser ? pdst_q : rd;
      if (res.rd_index != 5'd0) begin
        res.rd_write = 1'b1;
        res.rd_value = wval;
      end else begin
        res.rd_index = 5'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i < 32; i++) rf_q[i] <= '0;
      pc_q <= '0; lp_q <= 1'b0; pdst_q <= '0; pkind_q <= '0;
    end else if (acc) begin
      pc_q <= pc_d; lp_q <= lp_d; pdst_q <= pdst_d; pkind_q <= pkind_d;
      if (res.rd_write) rf_q[res.rd_index] <= res.rd_value;
    end
  end

  // Output register plus skid stage.
  assign s_axis_tready = !skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || m_axis_tready) begin
        out_vld_q <= skid_vld_q || acc;
        skid_vld_q <= 1'b0;
      end else if (acc) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || m_axis_tready) out_q <= skid_vld_q ? skid_q : res;
    else if (acc) skid_q <= res;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {7'd0, out_q.rd_value, out_q.rd_index, out_q.rd_write,
                          out_q.mem_size, out_q.mem_addr, out_q.mem_req, out_q.next_pc};

endmodule

// ===== src/rv32e_checker.sv =====
// Port-level checker for rv32i_base_execute_unit, bound into every instance of it.
// Depends on rv32e_pkg.
module rv32e_checker
  import rv32e_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata,
  input logic [2:0]   m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  a_accept_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted transaction gave no result");

  a_status_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= 3'd5)
    else $error("status out of range");

  a_req_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tuser == ST_PENDING)
    else $error("load request without pending status");

  a_x0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[67] |-> m_axis_tdata[72:68] != 5'd0)
    else $error("write to x0 reported");

endmodule

bind rv32i_base_execute_unit rv32e_checker u_chk (.*);

// ===== tb/sv/rv32i_base_execute_unit_checker.sv =====
// Checker for the partial RV32I execute unit: watches both stream channels,
// predicts each result from its own register file and pc, and compares.
// Depends on rv32e_pkg.
module rv32i_base_execute_unit_checker
  import rv32e_pkg::*;
#(
  parameter int NUM_REGS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [111:0] m_axis_tdata,
  input  logic [2:0]   m_axis_tuser,
  output int           fail_count_o,
  output int           pending_results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] rd_value;
    logic [4:0]  rd_index;
    logic        rd_write;
    logic [1:0]  mem_size;
    logic [31:0] mem_addr;
    logic        mem_req;
    logic [31:0] next_pc;
    logic [2:0]  status;
  } exec_result_t;

  logic [31:0] gpr [32];
  logic [31:0] pc_q;
  logic        ld_busy;
  logic [4:0]  ld_dest;
  logic [2:0]  ld_kind;
  exec_result_t expected_q[$];
  int fails;

  assign fail_count_o      = fails;
  assign pending_results_o = expected_q.size();

  function automatic logic [31:0] sx(logic [31:0] v, int bits);
    logic [31:0] m;
    m = (32'h1 << bits) - 1;
    v &= m;
    if (v[bits-1]) v |= ~m;
    return v;
  endfunction

  task automatic execute_item(logic mode, logic [31:0] w, logic [31:0] ld, logic flt);
    exec_result_t r;
    logic        wr, cond;
    logic [31:0] val, tgt, a, b, immi, immu, immb, immj;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    r = '0;
    r.status = ST_OK;
    wr = 0; val = 0;
    rd = w[11:7]; rs1 = w[19:15]; rs2 = w[24:20]; f3 = w[14:12]; f7 = w[31:25];
    a = gpr[rs1]; b = gpr[rs2];
    immi = sx(w >> 20, 12);
    immu = {w[31:12], 12'b0};
    immb = sx({w[31], w[7], w[30:25], w[11:8], 1'b0}, 13);
    immj = sx({w[31], w[19:12], w[20], w[30:21], 1'b0}, 21);
    if (mode) begin
      if (ld_busy) begin
        if (flt) begin
          r.status = ST_LFAULT;
        end else begin
          case (ld_kind)
            F3_LB:  val = sx(ld, 8);
            F3_LH:  val = sx(ld, 16);
            F3_LBU: val = {24'b0, ld[7:0]};
            F3_LHU: val = {16'b0, ld[15:0]};
            default: val = ld;
          endcase
          wr = 1; rd = ld_dest;
          pc_q += 4;
        end
        ld_busy = 0;
      end
    end else if (ld_busy) begin
      r.status = ST_BUSY;
    end else if (w[1:0] != 2'b11 || w[4:2] == LEN_LONG) begin
      r.status = ST_ILLEGAL;
    end else begin
      case (w[6:0])
        OPC_LUI, OPC_AUIPC: begin
          if (rd >= NUM_REGS) r.status = ST_ILLEGAL;
          else begin
            wr = 1; val = (w[6:0] == OPC_LUI) ? immu : pc_q + immu; pc_q += 4;
          end
        end
        OPC_JAL, OPC_JALR: begin
          if (rd >= NUM_REGS || (w[6:0] == OPC_JALR && (f3 != 0 || rs1 >= NUM_REGS)))
            r.status = ST_ILLEGAL;
          else begin
            tgt = (w[6:0] == OPC_JAL) ? pc_q + immj : (a + immi) & ~32'h1;
            if (tgt[1:0] != 0) r.status = ST_MISALIGN;
            else begin
              wr = 1; val = pc_q + 4; pc_q = tgt;
            end
          end
        end
        OPC_BRANCH: begin
          if (f3 == 2 || f3 == 3 || rs1 >= NUM_REGS || rs2 >= NUM_REGS)
            r.status = ST_ILLEGAL;
          else begin
            case (f3)
              F3_BEQ:  cond = a == b;
              F3_BNE:  cond = a != b;
              F3_BLT:  cond = $signed(a) < $signed(b);
              F3_BGE:  cond = $signed(a) >= $signed(b);
              F3_BLTU: cond = a < b;
              default: cond = a >= b;
            endcase
            tgt = pc_q + immb;
            if (!cond) pc_q += 4;
            else if (tgt[1:0] != 0) r.status = ST_MISALIGN;
            else pc_q = tgt;
          end
        end
        OPC_LOAD: begin
          if (f3 == 3 || f3 >= 6 || rd >= NUM_REGS || rs1 >= NUM_REGS)
            r.status = ST_ILLEGAL;
          else begin
            r.mem_req = 1; r.mem_addr = a + immi; r.mem_size = f3[1:0];
            ld_busy = 1; ld_dest = rd; ld_kind = f3;
            r.status = ST_PENDING;
          end
        end
        OPC_OPIMM: begin
          if (rd >= NUM_REGS || rs1 >= NUM_REGS) r.status = ST_ILLEGAL;
          else begin
            case (f3)
              F3_ADDI:  val = a + immi;
              F3_SLLI:  if (f7 != 0) r.status = ST_ILLEGAL; else val = a << rs2;
              F3_SLTI:  val = {31'b0, $signed(a) < $signed(immi)};
              F3_SLTIU: val = {31'b0, a < immi};
              F3_XORI:  val = a ^ immi;
              F3_SRI: begin
                if (f7 == 0) val = a >> rs2;
                else if (f7 == F7_ALT) val = $signed(a) >>> rs2;
                else r.status = ST_ILLEGAL;
              end
              F3_ORI:   val = a | immi;
              default:  val = a & immi;
            endcase
            if (r.status == ST_OK) begin
              wr = 1; pc_q += 4;
            end
          end
        end
        default: r.status = ST_ILLEGAL;
      endcase
    end
    if (wr && rd != 0) begin
      gpr[rd] = val;
      r.rd_write = 1; r.rd_index = rd; r.rd_value = val;
    end
    r.next_pc = pc_q;
    expected_q.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    exec_result_t got, exp_r;
    if (!rst_ni) begin
      foreach (gpr[i]) gpr[i] = '0;
      pc_q = '0; ld_busy = 0; ld_dest = '0; ld_kind = '0;
      expected_q.delete();
      fails = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[104:0], m_axis_tuser};
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result transaction %h", $time, got);
        end else begin
          exp_r = expected_q.pop_front();
          if (got.status !== exp_r.status || got.next_pc !== exp_r.next_pc ||
              got.mem_req !== exp_r.mem_req || got.mem_addr !== exp_r.mem_addr ||
              got.mem_size !== exp_r.mem_size || got.rd_write !== exp_r.rd_write ||
              got.rd_index !== exp_r.rd_index || got.rd_value !== exp_r.rd_value) begin
            fails++;
            $display("%0t: result mismatch expected %h actual %h", $time, exp_r, got);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        execute_item(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
                     s_axis_tdata[64]);
    end
  end
endmodule

// ===== tb/sv/rv32i_base_execute_unit_tb.sv =====
// Top of the execute unit testbench: clock, reset, stimulus and verdict.
// Depends on rv32e_pkg, rv32i_base_execute_unit and its checker module.
module rv32i_base_execute_unit_tb
  import rv32e_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [111:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  int fail_count, pending_results;
  int src_idle_pct = 30, sink_idle_pct = 50;
  bit sink_hold = 0;
  longint cycles = 0;

  always #1 clk_i = ~clk_i;

  rv32i_base_execute_unit dut (.*);
  rv32i_base_execute_unit_checker chk (.*, .fail_count_o(fail_count),
                                       .pending_results_o(pending_results));

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 200000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk_i)
    m_axis_tready <= rst_ni && !sink_hold && ($urandom_range(99) >= sink_idle_pct);

  function automatic logic [31:0] rnd_instr();
    logic [31:0] w;
    int k;
    w = $urandom();
    // registers are mostly small so that loaded values are reused
    w[19:15] = 5'($urandom_range(7));
    w[24:20] = ($urandom_range(3) == 0) ? w[24:20] : 5'($urandom_range(7));
    w[11:7] = 5'($urandom_range(7));
    k = $urandom_range(99);
    if (k < 6) return w;
    case ($urandom_range(7))
      0: w[6:0] = OPC_LUI;
      1: w[6:0] = OPC_AUIPC;
      2: w[6:0] = OPC_JAL;
      3: begin w[6:0] = OPC_JALR; if (k > 15) w[14:12] = 3'd0; end
      4: w[6:0] = OPC_BRANCH;
      5: w[6:0] = OPC_LOAD;
      default: begin
        w[6:0] = OPC_OPIMM;
        if (k > 15 && w[14:12] inside {F3_SLLI, F3_SRI}) w[31:25] = w[30] ? F7_ALT : 7'd0;
      end
    endcase
    // keep control flow mostly aligned
    if (k > 20 && w[6:0] == OPC_JAL) w[21] = 1'b0;
    if (k > 20 && w[6:0] == OPC_BRANCH) w[8] = 1'b0;
    if (k > 20 && w[6:0] == OPC_JALR) w[21:20] = 2'b0;
    return w;
  endfunction

  task automatic send(logic mode, logic [31:0] w, logic [31:0] ld = '0, logic flt = 0);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {7'b0, flt, ld, w};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_random();
    if ($urandom_range(99) < 40) send(1, $urandom(), $urandom(), $urandom_range(9) == 0);
    else send(0, rnd_instr());
  endtask

  task automatic wait_empty();
    s_axis_tvalid <= 0;
    while (pending_results != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // directed: ALU, upper, loads of all widths, jumps, branches, bad lengths
    send(0, {12'hfff, 5'd0, F3_ADDI, 5'd1, OPC_OPIMM});
    send(0, {12'h7ff, 5'd0, F3_ADDI, 5'd2, OPC_OPIMM});
    send(0, {7'd0, 5'd31, 5'd1, F3_SLLI, 5'd3, OPC_OPIMM});
    send(0, {F7_ALT, 5'd4, 5'd1, F3_SRI, 5'd4, OPC_OPIMM});
    send(0, {7'd0, 5'd4, 5'd1, F3_SRI, 5'd5, OPC_OPIMM});
    send(0, {7'd1, 5'd4, 5'd1, F3_SRI, 5'd5, OPC_OPIMM});
    send(0, {12'h800, 5'd1, F3_SLTI, 5'd6, OPC_OPIMM});
    send(0, {12'h800, 5'd1, F3_SLTIU, 5'd6, OPC_OPIMM});
    send(0, {20'hfffff, 5'd7, OPC_LUI});
    send(0, {20'h80000, 5'd7, OPC_AUIPC});
    send(0, {12'h004, 5'd1, F3_LB, 5'd8, OPC_LOAD});
    send(0, 32'h13);
    send(1, 0, 32'hffffff80);
    send(0, {12'h0, 5'd1, F3_LHU, 5'd0, OPC_LOAD});
    send(1, 0, 32'h8765_f00d);
    send(0, {12'h0, 5'd2, F3_LW, 5'd9, OPC_LOAD});
    send(1, 0, 32'hffffffff, 1);
    send(1, 0, 32'h1);
    send(0, {1'b0, 10'd4, 1'b0, 8'd0, 5'd1, OPC_JAL});
    send(0, {1'b0, 10'd1, 1'b0, 8'd0, 5'd1, OPC_JAL});
    send(0, {12'h2, 5'd1, 3'd0, 5'd1, OPC_JALR});
    send(0, {7'd0, 5'd1, 5'd1, F3_BEQ, 5'd8, OPC_BRANCH});
    send(0, {7'd0, 5'd2, 5'd1, F3_BLT, 5'd2, OPC_BRANCH});
    send(0, 32'hffff_fff0 | 7'b0011111);
    send(0, 32'h0);
    // random phases
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct  = (ph == 0) ? 30 : (ph == 1) ? 50 : 0;
      sink_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 30 : 0;
      for (int i = 0; i < 500; i++) begin
        if (i == 100) begin
          sink_hold = 1;
          fork
            begin repeat (60) @(negedge clk_i); sink_hold = 0; end
          join_none
        end
        if (i == 300) wait_empty();
        send_random();
      end
    end
    wait_empty();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
